/* hdl/swwsq_pkg.sv */
// Shared types and constants for the sliding window weighted square count block.
package swwsq_pkg;

   localparam int DEF_ARRAY_DEPTH = 4096;
   localparam int DEF_VALUE_RANGE = 65536;

   localparam int INDEX_W = 12;
   localparam int VALUE_W = 16;
   localparam int POWER_W = 48;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // classified item kinds handed from front to back
   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_SKIP  = 2'd1,
      KIND_QUERY = 2'd2,
      KIND_BAD   = 2'd3
   } item_kind_type;

   typedef struct packed {
      logic clearing;
      logic busy;
   } status_type;

endpackage

/* hdl/swwsq_front.sv */
// Front end: accepts beats, classifies and saturates them, queues them for the back end.
module swwsq_front
   import swwsq_pkg::*;
#(
   parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH,
   parameter int VALUE_RANGE = DEF_VALUE_RANGE,
   localparam int AW = $clog2(ARRAY_DEPTH),
   localparam int VW = $clog2(VALUE_RANGE)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_func,
   input  logic [INDEX_W-1:0] req_index,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [INDEX_W-1:0] req_left,
   input  logic [INDEX_W-1:0] req_right,
   input  status_type         status,
   output logic               q_valid,
   input  logic               q_pop,
   output item_kind_type      q_kind,
   output logic [AW-1:0]      q_index,
   output logic [VW-1:0]      q_value,
   output logic [AW-1:0]      q_left,
   output logic [AW-1:0]      q_right
);

   localparam int QDEPTH = 2;

   function automatic logic [AW-1:0] sat_pos(input logic [INDEX_W-1:0] p);
      if (32'(p) > 32'(ARRAY_DEPTH - 1))
         return AW'(ARRAY_DEPTH - 1);
      return AW'(p);
   endfunction

   item_kind_type kind_mem [QDEPTH];
   logic [AW-1:0] index_mem [QDEPTH];
   logic [VW-1:0] value_mem [QDEPTH];
   logic [AW-1:0] left_mem [QDEPTH];
   logic [AW-1:0] right_mem [QDEPTH];

   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept;
   logic       do_pop;
   item_kind_type new_kind;
   logic [VW-1:0] new_value;

   assign req_full = (count_ff == 2'(QDEPTH)) || status.clearing;
   assign accept   = req_push && !req_full;
   assign q_valid  = (count_ff != 2'd0);
   assign do_pop   = q_pop && q_valid;

   always_comb begin
      if (req_func == FUNC_LOAD) begin
         new_kind = (32'(req_index) < 32'(ARRAY_DEPTH)) ? KIND_LOAD : KIND_SKIP;
      end else begin
         new_kind = (req_right < req_left) ? KIND_BAD : KIND_QUERY;
      end
      if (32'(req_value) >= 32'(VALUE_RANGE))
         new_value = VW'(VALUE_RANGE - 1);
      else
         new_value = VW'(req_value);
   end

   always_comb begin
      wr_ptr_in = accept ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(accept) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_mem[wr_ptr_ff]  <= new_kind;
         index_mem[wr_ptr_ff] <= sat_pos(req_index);
         value_mem[wr_ptr_ff] <= new_value;
         left_mem[wr_ptr_ff]  <= sat_pos(req_left);
         right_mem[wr_ptr_ff] <= sat_pos(req_right);
      end
   end

   assign q_kind  = kind_mem[rd_ptr_ff];
   assign q_index = index_mem[rd_ptr_ff];
   assign q_value = value_mem[rd_ptr_ff];
   assign q_left  = left_mem[rd_ptr_ff];
   assign q_right = right_mem[rd_ptr_ff];

endmodule

/* hdl/swwsq_back.sv */
// Back end: element store, value histogram, window stepping sequencer and result register.
module swwsq_back
   import swwsq_pkg::*;
#(
   parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH,
   parameter int VALUE_RANGE = DEF_VALUE_RANGE,
   localparam int AW = $clog2(ARRAY_DEPTH),
   localparam int VW = $clog2(VALUE_RANGE)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_pop,
   input  item_kind_type      q_kind,
   input  logic [AW-1:0]      q_index,
   input  logic [VW-1:0]      q_value,
   input  logic [AW-1:0]      q_left,
   input  logic [AW-1:0]      q_right,
   output status_type         status,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [POWER_W-1:0] rsp_power,
   output logic               rsp_error
);

   localparam int PW = AW + 1;
   localparam int CW = $clog2(ARRAY_DEPTH + 1);
   localparam int KW = CW + 1;
   localparam int MW = KW + VW;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PLAN  = 6'b000010,
      ST_EWAIT = 6'b000100,
      ST_CWAIT = 6'b001000,
      ST_ACC   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [AW-1:0]      start_ff, start_in;
   logic [PW-1:0]      e1_ff, e1_in;      // one past window end
   logic [POWER_W-1:0] sum_ff, sum_in;
   logic [AW-1:0]      nl_ff, nl_in;
   logic [AW-1:0]      nr_ff, nr_in;
   logic [AW-1:0]      ld_idx_ff, ld_idx_in;
   logic [VW-1:0]      ld_val_ff, ld_val_in;
   logic               is_load_ff, is_load_in;
   logic               load_up_ff, load_up_in;
   logic               err_ff, err_in;
   logic               dir_up_ff, dir_up_in;
   logic               direct_ff, direct_in;
   logic [VW-1:0]      step_val_ff, step_val_in;
   logic [MW-1:0]      prod_ff, prod_in;
   logic [CW-1:0]      new_cnt_ff, new_cnt_in;
   logic               skip_ff, skip_in;
   logic               out_valid_ff, out_valid_in;
   logic [POWER_W-1:0] out_power_ff, out_power_in;
   logic               out_error_ff, out_error_in;
   logic               clr_busy_ff;
   logic [VW-1:0]      clr_idx_ff;

   logic [VW-1:0] elem_mem [ARRAY_DEPTH];
   logic [CW-1:0] cnt_mem [VALUE_RANGE];
   logic [VW-1:0] elem_rd_ff;
   logic [CW-1:0] cnt_rd_ff;

   logic          elem_we;
   logic [AW-1:0] elem_wa;
   logic [VW-1:0] elem_wd;
   logic [AW-1:0] elem_ra;
   logic [VW-1:0] cnt_ra;
   logic          cnt_we;
   logic [KW-1:0] k_fac;
   logic [PW-1:0] e1_dec;
   logic          in_window;

   assign e1_dec = e1_ff - PW'(1);
   assign in_window = ({1'b0, q_index} >= {1'b0, start_ff}) && ({1'b0, q_index} < e1_ff);

   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      e1_in        = e1_ff;
      sum_in       = sum_ff;
      nl_in        = nl_ff;
      nr_in        = nr_ff;
      ld_idx_in    = ld_idx_ff;
      ld_val_in    = ld_val_ff;
      is_load_in   = is_load_ff;
      load_up_in   = load_up_ff;
      err_in       = err_ff;
      dir_up_in    = dir_up_ff;
      direct_in    = direct_ff;
      step_val_in  = step_val_ff;
      prod_in      = prod_ff;
      new_cnt_in   = new_cnt_ff;
      skip_in      = skip_ff;
      out_valid_in = out_valid_ff;
      out_power_in = out_power_ff;
      out_error_in = out_error_ff;
      q_pop        = 1'b0;
      elem_we      = 1'b0;
      elem_wa      = ld_idx_ff;
      elem_wd      = ld_val_ff;
      elem_ra      = start_ff;
      cnt_ra       = elem_rd_ff;
      cnt_we       = 1'b0;
      k_fac        = '0;

      if (rsp_pop && out_valid_ff)
         out_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!clr_busy_ff && q_valid) begin
               q_pop      = 1'b1;
               nl_in      = q_left;
               nr_in      = q_right;
               ld_idx_in  = q_index;
               ld_val_in  = q_value;
               err_in     = 1'b0;
               is_load_in = 1'b0;
               unique case (q_kind)
                  KIND_BAD: begin
                     err_in   = 1'b1;
                     state_in = ST_OUT;
                  end
                  KIND_SKIP: begin
                     state_in = ST_OUT;
                  end
                  KIND_LOAD: begin
                     if (in_window) begin
                        // old value leaves the histogram first
                        elem_ra    = q_index;
                        is_load_in = 1'b1;
                        load_up_in = 1'b0;
                        dir_up_in  = 1'b0;
                        direct_in  = 1'b0;
                        state_in   = ST_EWAIT;
                     end else begin
                        elem_we  = 1'b1;
                        elem_wa  = q_index;
                        elem_wd  = q_value;
                        state_in = ST_OUT;
                     end
                  end
                  KIND_QUERY: begin
                     state_in = ST_PLAN;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_PLAN: begin
            priority if (nl_ff < start_ff) begin
               elem_ra   = start_ff - AW'(1);
               start_in  = start_ff - AW'(1);
               dir_up_in = 1'b1;
               direct_in = 1'b0;
               state_in  = ST_EWAIT;
            end else if (e1_ff <= {1'b0, nr_ff}) begin
               elem_ra   = e1_ff[AW-1:0];
               e1_in     = e1_ff + PW'(1);
               dir_up_in = 1'b1;
               direct_in = 1'b0;
               state_in  = ST_EWAIT;
            end else if (nl_ff > start_ff) begin
               elem_ra   = start_ff;
               start_in  = start_ff + AW'(1);
               dir_up_in = 1'b0;
               direct_in = 1'b0;
               state_in  = ST_EWAIT;
            end else if (e1_ff > ({1'b0, nr_ff} + PW'(1))) begin
               elem_ra   = e1_dec[AW-1:0];
               e1_in     = e1_dec;
               dir_up_in = 1'b0;
               direct_in = 1'b0;
               state_in  = ST_EWAIT;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_EWAIT: begin
            cnt_ra      = direct_ff ? ld_val_ff : elem_rd_ff;
            step_val_in = cnt_ra;
            state_in    = ST_CWAIT;
         end
         ST_CWAIT: begin
            if (dir_up_ff) begin
               k_fac      = {cnt_rd_ff, 1'b0} + KW'(1);
               new_cnt_in = cnt_rd_ff + CW'(1);
               skip_in    = 1'b0;
            end else begin
               k_fac      = {cnt_rd_ff, 1'b0} - KW'(1);
               new_cnt_in = cnt_rd_ff - CW'(1);
               skip_in    = (cnt_rd_ff == '0);
            end
            prod_in  = MW'(k_fac) * MW'(step_val_ff);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (!skip_ff) begin
               cnt_we = 1'b1;
               if (dir_up_ff)
                  sum_in = sum_ff + POWER_W'(prod_ff);
               else
                  sum_in = sum_ff - POWER_W'(prod_ff);
            end
            priority if (is_load_ff && !load_up_ff) begin
               // store new element, then add it to the histogram
               elem_we    = 1'b1;
               load_up_in = 1'b1;
               dir_up_in  = 1'b1;
               direct_in  = 1'b1;
               state_in   = ST_EWAIT;
            end else if (is_load_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_PLAN;
            end
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               out_power_in = err_ff ? '0 : sum_ff;
               out_error_in = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= '0;
         e1_ff        <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
         clr_busy_ff  <= 1'b1;
         clr_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         e1_ff        <= e1_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
         if (clr_busy_ff) begin
            clr_idx_ff <= clr_idx_ff + VW'(1);
            if (clr_idx_ff == VW'(VALUE_RANGE - 1))
               clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      nl_ff        <= nl_in;
      nr_ff        <= nr_in;
      ld_idx_ff    <= ld_idx_in;
      ld_val_ff    <= ld_val_in;
      is_load_ff   <= is_load_in;
      load_up_ff   <= load_up_in;
      err_ff       <= err_in;
      dir_up_ff    <= dir_up_in;
      direct_ff    <= direct_in;
      step_val_ff  <= step_val_in;
      prod_ff      <= prod_in;
      new_cnt_ff   <= new_cnt_in;
      skip_ff      <= skip_in;
      out_power_ff <= out_power_in;
      out_error_ff <= out_error_in;
   end

   always_ff @(posedge clock) begin
      if (elem_we)
         elem_mem[elem_wa] <= elem_wd;
      elem_rd_ff <= elem_mem[elem_ra];
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff)
         cnt_mem[clr_idx_ff] <= '0;
      else if (cnt_we)
         cnt_mem[step_val_ff] <= new_cnt_ff;
      cnt_rd_ff <= cnt_mem[cnt_ra];
   end

   assign status.clearing = clr_busy_ff;
   assign status.busy     = (state_ff != ST_IDLE);
   assign rsp_empty       = !out_valid_ff;
   assign rsp_power       = out_power_ff;
   assign rsp_error       = out_error_ff;

endmodule

/* hdl/sliding_window_weighted_square_count.sv */
// Top level of the sliding window weighted square count block.
//
// Input side is a queue: drive req_* and raise req_push; a beat is taken at a
// clock edge with req_push high and req_full low. req_func selects a load
// (write req_value at req_index) or a query (move the window to
// [req_left, req_right] and report the sum of count^2 * value over it).
// Result side is a queue too: while rsp_empty is low rsp_power/rsp_error hold
// the oldest result, taken at an edge with rsp_pop high.
// Every beat in gives exactly one result beat.
// A load outside the window or a reversed query goes straight to the output
// state; a load inside the window first removes the old value, then adds the
// new one. A query moves the window one step at a time until both ends reach
// the new bounds. Each step and each half of a load pass the shared histogram
// read/modify/write path: element read, count read, multiply, accumulate.
// A two-beat front queue keeps taking beats while the back end works or a
// result waits; when the result register is held by a stalled receiver the
// back end waits in its output state and the front queue fills, then req_full.
// Reset: the histogram memory is cleared one entry per cycle, with req_full
// high until the pass ends. Window starts empty.
module sliding_window_weighted_square_count
   import swwsq_pkg::*;
#(
   parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH,
   parameter int VALUE_RANGE = DEF_VALUE_RANGE
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_func,
   input  logic [INDEX_W-1:0] req_index,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [INDEX_W-1:0] req_left,
   input  logic [INDEX_W-1:0] req_right,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [POWER_W-1:0] rsp_power,
   output logic               rsp_error
);

   localparam int AW = $clog2(ARRAY_DEPTH);
   localparam int VW = $clog2(VALUE_RANGE);

   status_type    status;
   logic          q_valid;
   logic          q_pop;
   item_kind_type q_kind;
   logic [AW-1:0] q_index;
   logic [VW-1:0] q_value;
   logic [AW-1:0] q_left;
   logic [AW-1:0] q_right;

   // front: classify and queue
   swwsq_front #(
      .ARRAY_DEPTH(ARRAY_DEPTH),
      .VALUE_RANGE(VALUE_RANGE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_func  (req_func),
      .req_index (req_index),
      .req_value (req_value),
      .req_left  (req_left),
      .req_right (req_right),
      .status    (status),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_kind    (q_kind),
      .q_index   (q_index),
      .q_value   (q_value),
      .q_left    (q_left),
      .q_right   (q_right)
   );

   // back: window sequencer and histogram
   swwsq_back #(
      .ARRAY_DEPTH(ARRAY_DEPTH),
      .VALUE_RANGE(VALUE_RANGE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_kind    (q_kind),
      .q_index   (q_index),
      .q_value   (q_value),
      .q_left    (q_left),
      .q_right   (q_right),
      .status    (status),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_power (rsp_power),
      .rsp_error (rsp_error)
   );

`ifndef SYNTHESIS
   // flagged query always reports zero
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_error) |-> (rsp_power == '0))
      else $error("flagged result with nonzero power");

   // the histogram clear pass blocks input
   a_clear_full: assert property (@(posedge clock)
      reset |=> req_full)
      else $error("input open during clear pass");

   // back end never pulls from an empty queue or during clear
   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (q_valid && !status.clearing && !status.busy))
      else $error("queue pop while not ready");
`endif

endmodule
